>>> src/rgbyuv_pkg.sv
package rgbyuv_pkg;

    localparam int unsigned COMP_W         = 8;
    localparam int unsigned PAIR_SUM_W     = COMP_W + 1;
    localparam int unsigned BLOCK_SUM_W    = COMP_W + 2;
    localparam int unsigned LINE_W         = 3 * PAIR_SUM_W;
    localparam int unsigned PAIR_COUNT_W   = 11;
    localparam logic [PAIR_COUNT_W-1:0] PAIR_COUNT_RESET = 11'd320;

    localparam int unsigned LUMA_ACC_W     = 16;
    localparam logic [7:0] LUMA_R_COEF     = 8'd77;
    localparam logic [7:0] LUMA_G_COEF     = 8'd150;
    localparam logic [7:0] LUMA_B_COEF     = 8'd29;
    localparam logic [LUMA_ACC_W-1:0] LUMA_ROUND = 16'd128;

    localparam int unsigned CHROMA_ACC_W   = 20;
    localparam logic signed [8:0] CB_R_COEF = -9'sd43;
    localparam logic signed [8:0] CB_G_COEF = -9'sd85;
    localparam logic signed [8:0] CB_B_COEF = 9'sd128;
    localparam logic signed [8:0] CR_R_COEF = 9'sd128;
    localparam logic signed [8:0] CR_G_COEF = -9'sd107;
    localparam logic signed [8:0] CR_B_COEF = -9'sd21;
    // rounding 511 plus offset 128 << 10
    localparam logic signed [CHROMA_ACC_W-1:0] CHROMA_BIAS = 20'sd131583;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              start_of_frame;
    } t_pixel;

    typedef struct packed {
        logic [COMP_W-1:0] luma;
        logic [COMP_W-1:0] chroma_blue;
        logic [COMP_W-1:0] chroma_red;
        logic              chroma_valid;
    } t_result;

    typedef struct packed {
        logic column_odd;
        logic row_odd;
    } t_phase;

endpackage

>>> src/rgbyuv_ram.sv
module rgbyuv_ram #(
    parameter int unsigned WIDTH = 27,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/rgbyuv_ctrl.sv
module rgbyuv_ctrl #(
    parameter int unsigned MAX_PAIRS = 1024,
    localparam int unsigned PAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgbyuv_pkg::PAIR_COUNT_W-1:0] i_cfg_wdata,
    input  logic                                i_accept,
    input  logic                                i_sof,
    output rgbyuv_pkg::t_phase                  o_phase,
    output logic [PAW-1:0]                      o_pos
);

    localparam int unsigned CW = (PAW + 1 > rgbyuv_pkg::PAIR_COUNT_W) ?
                                 PAW + 1 : rgbyuv_pkg::PAIR_COUNT_W;
    localparam logic [CW-1:0] MAX_PAIRS_C = CW'(MAX_PAIRS);

    logic [rgbyuv_pkg::PAIR_COUNT_W-1:0] r_pair_count;
    logic [PAW-1:0]                      r_pos;
    rgbyuv_pkg::t_phase                  r_phase;

    logic [PAW-1:0]     n_pos;
    rgbyuv_pkg::t_phase n_phase;
    logic [CW-1:0]      count_ext;
    logic [CW-1:0]      limit;
    logic [CW-1:0]      pos_next_ext;

    // effective position after a frame start
    always_comb begin
        o_pos   = i_sof ? '0 : r_pos;
        o_phase = i_sof ? '0 : r_phase;
    end

    always_comb begin
        count_ext = CW'(r_pair_count);
        if (count_ext == '0) begin
            limit = CW'(1);
        end else if (count_ext > MAX_PAIRS_C) begin
            limit = MAX_PAIRS_C;
        end else begin
            limit = count_ext;
        end
        pos_next_ext = CW'(o_pos) + CW'(1);
    end

    always_comb begin
        n_pos   = o_pos;
        n_phase = o_phase;
        if (!o_phase.column_odd) begin
            n_phase.column_odd = 1'b1;
        end else begin
            n_phase.column_odd = 1'b0;
            if (pos_next_ext >= limit) begin
                n_pos           = '0;
                n_phase.row_odd = ~o_phase.row_odd;
            end else begin
                n_pos = pos_next_ext[PAW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= rgbyuv_pkg::PAIR_COUNT_RESET;
            r_pos        <= '0;
            r_phase      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pair_count <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
            end
        end
    end

endmodule

>>> src/rgbyuv_math.sv
module rgbyuv_math (
    input  logic [3*rgbyuv_pkg::COMP_W-1:0] i_pixel_rgb,
    input  logic [3*rgbyuv_pkg::COMP_W-1:0] i_first_rgb,
    input  logic [rgbyuv_pkg::LINE_W-1:0]   i_line_sums,
    input  logic                            i_chroma_en,
    output logic [rgbyuv_pkg::LINE_W-1:0]   o_pair_sums,
    output rgbyuv_pkg::t_result             o_result
);

    localparam int unsigned CW  = rgbyuv_pkg::COMP_W;
    localparam int unsigned SW  = rgbyuv_pkg::PAIR_SUM_W;
    localparam int unsigned BW  = rgbyuv_pkg::BLOCK_SUM_W;
    localparam int unsigned LW  = rgbyuv_pkg::LUMA_ACC_W;
    localparam int unsigned AW  = rgbyuv_pkg::CHROMA_ACC_W;

    logic [CW-1:0] r_c, g_c, b_c;
    logic [SW-1:0] sr, sg, sb;
    logic [BW-1:0] tr, tg, tb;
    logic [LW-1:0] luma_acc;
    logic signed [AW-1:0] str, stg, stb;
    logic signed [AW-1:0] cb_acc, cr_acc;

    always_comb begin
        r_c = i_pixel_rgb[3*CW-1:2*CW];
        g_c = i_pixel_rgb[2*CW-1:CW];
        b_c = i_pixel_rgb[CW-1:0];

        sr = SW'(r_c) + SW'(i_first_rgb[3*CW-1:2*CW]);
        sg = SW'(g_c) + SW'(i_first_rgb[2*CW-1:CW]);
        sb = SW'(b_c) + SW'(i_first_rgb[CW-1:0]);
        o_pair_sums = {sr, sg, sb};

        tr = BW'(sr) + BW'(i_line_sums[3*SW-1:2*SW]);
        tg = BW'(sg) + BW'(i_line_sums[2*SW-1:SW]);
        tb = BW'(sb) + BW'(i_line_sums[SW-1:0]);

        luma_acc = LW'(r_c) * LW'(rgbyuv_pkg::LUMA_R_COEF)
                 + LW'(g_c) * LW'(rgbyuv_pkg::LUMA_G_COEF)
                 + LW'(b_c) * LW'(rgbyuv_pkg::LUMA_B_COEF)
                 + rgbyuv_pkg::LUMA_ROUND;

        str = AW'(signed'({1'b0, tr}));
        stg = AW'(signed'({1'b0, tg}));
        stb = AW'(signed'({1'b0, tb}));

        cb_acc = str * AW'(rgbyuv_pkg::CB_R_COEF)
               + stg * AW'(rgbyuv_pkg::CB_G_COEF)
               + stb * AW'(rgbyuv_pkg::CB_B_COEF)
               + rgbyuv_pkg::CHROMA_BIAS;
        cr_acc = str * AW'(rgbyuv_pkg::CR_R_COEF)
               + stg * AW'(rgbyuv_pkg::CR_G_COEF)
               + stb * AW'(rgbyuv_pkg::CR_B_COEF)
               + rgbyuv_pkg::CHROMA_BIAS;

        o_result.luma         = luma_acc[LW-1:LW-CW];
        o_result.chroma_blue  = i_chroma_en ? cb_acc[17:10] : '0;
        o_result.chroma_red   = i_chroma_en ? cr_acc[17:10] : '0;
        o_result.chroma_valid = i_chroma_en;
    end

endmodule

>>> src/rgb_to_yuv420_converter.sv
// two register stages: an accepted input fills stage 1, then its result the output register
// throughput: 1 pixel per cycle unless i_ready stalls, set by the one-port-read line buffer
// the output register lets stage 1 take one more input while a result waits for i_ready
// synchronous active-low reset clears pipeline valids, position and pair_count (320)
// line buffer contents are not reset; they are written on even rows before odd rows read them
module rgb_to_yuv420_converter #(
    parameter int unsigned MAX_PAIRS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgbyuv_pkg::PAIR_COUNT_W-1:0] i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  rgbyuv_pkg::t_pixel                  i_pixel,
    output logic                                o_valid,
    input  logic                                i_ready,
    output rgbyuv_pkg::t_result                 o_result
);

    localparam int unsigned PAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int unsigned RGB_W = 3 * rgbyuv_pkg::COMP_W;

    logic               accept;
    logic               s1_fire;
    rgbyuv_pkg::t_phase phase;
    logic [PAW-1:0]     pos;

    logic [RGB_W-1:0]   r_hold;
    logic               r_s1_valid;
    logic [RGB_W-1:0]   r_s1_rgb;
    logic [RGB_W-1:0]   r_s1_first;
    rgbyuv_pkg::t_phase r_s1_phase;
    logic [PAW-1:0]     r_s1_pos;
    logic               r_out_valid;
    rgbyuv_pkg::t_result r_out;

    logic [rgbyuv_pkg::LINE_W-1:0] line_rd_data;
    logic [rgbyuv_pkg::LINE_W-1:0] pair_sums;
    rgbyuv_pkg::t_result           result;

    assign s1_fire = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign accept  = i_valid && o_ready;

    rgbyuv_ctrl #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_sof       (i_pixel.start_of_frame),
        .o_phase     (phase),
        .o_pos       (pos)
    );

    rgbyuv_ram #(
        .WIDTH (rgbyuv_pkg::LINE_W),
        .DEPTH (MAX_PAIRS)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire && r_s1_phase.column_odd && !r_s1_phase.row_odd),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (pair_sums),
        .i_rd_en   (accept && phase.column_odd && phase.row_odd),
        .i_rd_addr (pos),
        .o_rd_data (line_rd_data)
    );

    rgbyuv_math u_math (
        .i_pixel_rgb (r_s1_rgb),
        .i_first_rgb (r_s1_first),
        .i_line_sums (line_rd_data),
        .i_chroma_en (r_s1_phase.column_odd && r_s1_phase.row_odd),
        .o_pair_sums (pair_sums),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rgb   <= {i_pixel.red, i_pixel.green, i_pixel.blue};
            r_s1_first <= r_hold;
            r_s1_phase <= phase;
            r_s1_pos   <= pos;
            if (!phase.column_odd) begin
                r_hold <= {i_pixel.red, i_pixel.green, i_pixel.blue};
            end
        end
        if (s1_fire) begin
            r_out <= result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
